>>> rtl/core/hsvrgb_pkg.sv
package hsvrgb_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumStages = 4;
  localparam int unsigned HueStep   = 43;
  localparam int unsigned RemScale  = 6;
  localparam int unsigned FullScale = 255;
  localparam int unsigned FracShift = 8;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t hue;
    chan_t saturation;
    chan_t brightness;
  } hsv_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  typedef enum logic [2:0] {
    REGION_R_TO_Y = 3'd0,
    REGION_Y_TO_G = 3'd1,
    REGION_G_TO_C = 3'd2,
    REGION_C_TO_B = 3'd3,
    REGION_B_TO_M = 3'd4,
    REGION_M_TO_R = 3'd5
  } region_e;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic s4_load;
  } stage_en_t;

  function automatic region_e region_of(chan_t hue);
    region_e r;
    if (hue < chan_t'(HueStep)) begin
      r = REGION_R_TO_Y;
    end else if (hue < chan_t'(2 * HueStep)) begin
      r = REGION_Y_TO_G;
    end else if (hue < chan_t'(3 * HueStep)) begin
      r = REGION_G_TO_C;
    end else if (hue < chan_t'(4 * HueStep)) begin
      r = REGION_C_TO_B;
    end else if (hue < chan_t'(5 * HueStep)) begin
      r = REGION_B_TO_M;
    end else begin
      r = REGION_M_TO_R;
    end
    return r;
  endfunction

  function automatic chan_t region_base(region_e r);
    chan_t b;
    case (r)
      REGION_R_TO_Y: b = chan_t'(0);
      REGION_Y_TO_G: b = chan_t'(HueStep);
      REGION_G_TO_C: b = chan_t'(2 * HueStep);
      REGION_C_TO_B: b = chan_t'(3 * HueStep);
      REGION_B_TO_M: b = chan_t'(4 * HueStep);
      REGION_M_TO_R: b = chan_t'(5 * HueStep);
      default:       b = chan_t'(0);
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/hsvrgb_datapath.sv
module hsvrgb_datapath (
  input  logic              clk_i,
  input  hsvrgb_pkg::stage_en_t en_i,
  input  hsvrgb_pkg::hsv_t  pix_i,
  output hsvrgb_pkg::rgb_t  pix_o
);

  localparam int unsigned W  = hsvrgb_pkg::ChanW;
  localparam int unsigned PW = 2 * W;

  // stage 1: region and scaled remainder
  hsvrgb_pkg::region_e reg1_q, reg1_d;
  hsvrgb_pkg::chan_t   rem1_q, rem1_d;
  hsvrgb_pkg::chan_t   sat1_q, val1_q;
  logic                grey1_q;
  hsvrgb_pkg::chan_t   diff1;

  always_comb begin
    reg1_d = hsvrgb_pkg::region_of(pix_i.hue);
    diff1  = pix_i.hue - hsvrgb_pkg::region_base(reg1_d);
    rem1_d = W'(diff1 * W'(hsvrgb_pkg::RemScale));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1_load) begin
      reg1_q  <= reg1_d;
      rem1_q  <= rem1_d;
      sat1_q  <= pix_i.saturation;
      val1_q  <= pix_i.brightness;
      grey1_q <= (pix_i.saturation == '0);
    end
  end

  // stage 2: saturation-scaled fractions
  logic [PW-1:0]       prod_a, prod_b;
  hsvrgb_pkg::chan_t   fa2_q, fb2_q, ns2_q, val2_q;
  hsvrgb_pkg::region_e reg2_q;
  logic                grey2_q;

  assign prod_a = PW'(sat1_q) * PW'(rem1_q);
  assign prod_b = PW'(sat1_q) * PW'(W'(hsvrgb_pkg::FullScale) - rem1_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s2_load) begin
      fa2_q   <= prod_a[hsvrgb_pkg::FracShift +: W];
      fb2_q   <= prod_b[hsvrgb_pkg::FracShift +: W];
      ns2_q   <= W'(hsvrgb_pkg::FullScale) - sat1_q;
      val2_q  <= val1_q;
      reg2_q  <= reg1_q;
      grey2_q <= grey1_q;
    end
  end

  // stage 3: p, q, t
  logic [PW-1:0]       prod_p, prod_q, prod_t;
  hsvrgb_pkg::chan_t   p3_q, q3_q, t3_q, val3_q;
  hsvrgb_pkg::region_e reg3_q;
  logic                grey3_q;

  assign prod_p = PW'(val2_q) * PW'(ns2_q);
  assign prod_q = PW'(val2_q) * PW'(W'(hsvrgb_pkg::FullScale) - fa2_q);
  assign prod_t = PW'(val2_q) * PW'(W'(hsvrgb_pkg::FullScale) - fb2_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s3_load) begin
      p3_q    <= prod_p[hsvrgb_pkg::FracShift +: W];
      q3_q    <= prod_q[hsvrgb_pkg::FracShift +: W];
      t3_q    <= prod_t[hsvrgb_pkg::FracShift +: W];
      val3_q  <= val2_q;
      reg3_q  <= reg2_q;
      grey3_q <= grey2_q;
    end
  end

  // stage 4: channel arrangement
  hsvrgb_pkg::rgb_t rgb_d, rgb_q;

  always_comb begin
    if (grey3_q) begin
      rgb_d = '{red: val3_q, green: val3_q, blue: val3_q};
    end else begin
      case (reg3_q)
        hsvrgb_pkg::REGION_R_TO_Y: rgb_d = '{red: val3_q, green: t3_q,   blue: p3_q};
        hsvrgb_pkg::REGION_Y_TO_G: rgb_d = '{red: q3_q,   green: val3_q, blue: p3_q};
        hsvrgb_pkg::REGION_G_TO_C: rgb_d = '{red: p3_q,   green: val3_q, blue: t3_q};
        hsvrgb_pkg::REGION_C_TO_B: rgb_d = '{red: p3_q,   green: q3_q,   blue: val3_q};
        hsvrgb_pkg::REGION_B_TO_M: rgb_d = '{red: t3_q,   green: p3_q,   blue: val3_q};
        default:                   rgb_d = '{red: val3_q, green: p3_q,   blue: q3_q};
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4_load) begin
      rgb_q <= rgb_d;
    end
  end

  assign pix_o = rgb_q;

endmodule

>>> rtl/core/hsv_to_rgb_8bit_unit.sv
// HSV to RGB converter, 8 bits per channel.
// Input channel: in_valid_i / in_ready_o with in_data_i carrying hue,
// saturation and brightness. Output channel: out_valid_o / out_ready_i
// with out_data_o carrying red, green and blue. An item moves on a rising
// edge where valid and ready are both high.
// The accept edge loads stage 1 (region/remainder) and the item then passes
// the other three register stages (saturation products, p/q/t products,
// channel select into the output register) to out_valid_o. No stage is more
// than one 8x8 multiply deep.
// Throughput: one item per cycle while out_ready_i is high.
// Stall: when out_ready_i is low, items close up behind the output register;
// in_ready_o drops only when all four stages hold an item. Nothing is lost
// or repeated.
// Reset: rst_ni clears all valid bits; the pipeline comes up empty and
// in_ready_o is high. The conversion keeps no other state.
module hsv_to_rgb_8bit_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hsvrgb_pkg::hsv_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hsvrgb_pkg::rgb_t out_data_o
);

  localparam int unsigned NumStages = hsvrgb_pkg::NumStages;

  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] rdy;
  hsvrgb_pkg::stage_en_t en;

  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en.s1_load = rdy[0] && in_valid_i;
  assign en.s2_load = rdy[1] && vld_q[0];
  assign en.s3_load = rdy[2] && vld_q[1];
  assign en.s4_load = rdy[3] && vld_q[2];

  hsvrgb_datapath u_datapath (
    .clk_i (clk_i),
    .en_i  (en),
    .pix_i (in_data_i),
    .pix_o (out_data_o)
  );

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStages-1];

  a_no_block_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output drains");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (vld_q == '1))
    else $error("input stalled with a free stage");

  a_accept_reaches_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted item missing from first stage");

  a_item_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages-2] && rdy[NumStages-1]) |=> out_valid_o)
    else $error("item lost before output register");

endmodule
